// ===== rtl/psc_pkg.sv =====
// Shared types and constants of the panel setpoint controller.
package psc_pkg;

    localparam logic [1:0] VIEW_READBACK = 2'd0;
    localparam logic [1:0] VIEW_SETPOINT = 2'd1;
    localparam logic [1:0] VIEW_PRESET   = 2'd2;

    localparam logic [2:0] REG_MAX_VOLTAGE = 3'd0;
    localparam logic [2:0] REG_MAX_CURRENT = 3'd1;
    localparam logic [2:0] REG_MAX_POWER   = 3'd2;
    localparam logic [2:0] REG_SHORT_HOLD  = 3'd3;
    localparam logic [2:0] REG_LONG_HOLD   = 3'd4;

    localparam int KEY_TRACK = 0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADJUST,
        ST_LIMIT,
        ST_DIVIDE,
        ST_FINISH,
        ST_OUTPUT
    } psc_state_t;

    typedef struct packed {
        logic load;
        logic adjust;
        logic limit;
        logic div_start;
        logic finish;
        logic emit;
    } psc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic chan;
    } psc_status_t;

    // Encoder acceleration: x10 beyond one detent, then x5 beyond 30.
    function automatic logic signed [15:0] psc_accel(input logic signed [7:0] d);
        logic signed [15:0] x;
        x = 16'(d);
        if (x > 16'sd1 || x < -16'sd1) x = x * 16'sd10;
        if (x > 16'sd30 || x < -16'sd30) x = x * 16'sd5;
        return x;
    endfunction

endpackage

// ===== rtl/psc_divider.sv =====
// Restoring divider, one quotient bit a cycle.
module psc_divider import psc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [24:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = '0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            trial = {rem_reg[23:0], quo_reg[31]};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = busy_reg && (cnt_reg == 6'd1);
    assign quotient = quo_next;
endmodule

// ===== rtl/psc_controller.sv =====
// Sequencing state machine of the panel controller.
module psc_controller import psc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  psc_status_t status,
    output psc_cmd_t    cmd
);
    psc_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_ADJUST;
            ST_ADJUST: state_next = ST_LIMIT;
            ST_LIMIT:  state_next = status.need_div ? ST_DIVIDE : ST_FINISH;
            ST_DIVIDE: if (status.div_done) state_next = ST_FINISH;
            ST_FINISH: state_next = status.chan ? ST_OUTPUT : ST_ADJUST;
            ST_OUTPUT: if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ADJUST: cmd.adjust = 1'b1;
            ST_LIMIT: begin
                cmd.limit     = 1'b1;
                cmd.div_start = status.need_div;
            end
            ST_DIVIDE: cmd = '0;
            ST_FINISH: cmd.finish = 1'b1;
            ST_OUTPUT: begin
                out_valid = 1'b1;
                cmd.emit  = out_ready;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// ===== rtl/psc_datapath.sv =====
// Setpoint, view and status datapath of the panel controller.
module psc_datapath import psc_pkg::*; #(
    parameter int SETPOINT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  psc_cmd_t          cmd,
    output psc_status_t       status,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic signed [7:0] volt_delta_a,
    input  logic signed [7:0] curr_delta_a,
    input  logic signed [7:0] volt_delta_b,
    input  logic signed [7:0] curr_delta_b,
    input  logic [4:0]        key_presses,
    input  logic              link_ok_a,
    input  logic              reported_on_a,
    input  logic              link_ok_b,
    input  logic              reported_on_b,
    output logic [15:0]       volt_cmd_a,
    output logic [15:0]       curr_cmd_a,
    output logic              on_cmd_a,
    output logic [15:0]       volt_cmd_b,
    output logic [15:0]       curr_cmd_b,
    output logic              on_cmd_b,
    output logic              tracking_on,
    output logic [1:0]        view_a,
    output logic [1:0]        view_b
);
    localparam int SB = SETPOINT_BITS;
    localparam logic [SB-1:0] SP_MAX = {SB{1'b1}};

    logic [15:0] max_v_reg, max_i_reg;
    logic [31:0] max_p_reg;
    logic [6:0]  short_reg, long_reg;

    logic [SB-1:0] volt_reg [2];
    logic [SB-1:0] curr_reg [2];
    logic [1:0]    on_reg, last_reg, cmdon_reg;
    logic [1:0]    view_reg [2];
    logic [6:0]    hold_reg [2];
    logic          track_reg;

    logic signed [7:0] in_d_reg [4];
    logic [4:0]        keys_reg;
    logic [1:0]        link_reg, rep_reg;
    logic              chan_reg;

    logic signed [15:0] dv_reg, di_reg;
    logic [SB-1:0]      nv_reg, ni_reg;
    logic               div_cur_reg;

    logic signed [15:0] dv_c, di_c;
    logic [SB-1:0]      lim_v, lim_i, adj_v, adj_i;
    logic [63:0]        prod;
    logic               need_div;
    logic               div_done;
    logic [31:0]        quot;

    function automatic logic [SB-1:0] adj(input logic [SB-1:0] cur,
                                         input logic signed [15:0] d,
                                         input logic [SB-1:0] lim);
        logic signed [31:0] t;
        t = $signed({{(32-SB){1'b0}}, cur}) + 32'(d);
        if (t < 0) return '0;
        if (t > $signed({{(32-SB){1'b0}}, lim})) return lim;
        return t[SB-1:0];
    endfunction

    always_comb begin
        dv_c  = psc_accel(in_d_reg[{chan_reg, 1'b0}]);
        di_c  = psc_accel(in_d_reg[{chan_reg, 1'b1}]);
        lim_v = (SB > 16 || {16'(0), max_v_reg} < 32'(SP_MAX)) ? SB'(max_v_reg) : SP_MAX;
        lim_i = (SB > 16 || {16'(0), max_i_reg} < 32'(SP_MAX)) ? SB'(max_i_reg) : SP_MAX;
        adj_v = adj(volt_reg[chan_reg], dv_c, lim_v);
        adj_i = adj(curr_reg[chan_reg], di_c, lim_i);
        prod  = 64'(nv_reg) * 64'(ni_reg);
        need_div = !(chan_reg && track_reg) && (prod > 64'(max_p_reg));
    end

    assign status.need_div = need_div;
    assign status.div_done = div_done;
    assign status.chan     = chan_reg;

    psc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (max_p_reg),
        .divisor  ((dv_reg > 0) ? 24'(nv_reg) : 24'(ni_reg)),
        .done     (div_done),
        .quotient (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_v_reg <= 16'hffff;
            max_i_reg <= 16'hffff;
            max_p_reg <= 32'hffffffff;
            short_reg <= 7'd20;
            long_reg  <= 7'd100;
            for (int c = 0; c < 2; c++) begin
                volt_reg[c] <= '0;
                curr_reg[c] <= '0;
                view_reg[c] <= VIEW_READBACK;
                hold_reg[c] <= '0;
            end
            on_reg    <= '0;
            last_reg  <= '0;
            cmdon_reg <= '0;
            track_reg <= 1'b0;
            chan_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_MAX_VOLTAGE: max_v_reg <= cfg_data[15:0];
                    REG_MAX_CURRENT: max_i_reg <= cfg_data[15:0];
                    REG_MAX_POWER:   max_p_reg <= cfg_data;
                    REG_SHORT_HOLD:  short_reg <= cfg_data[6:0];
                    REG_LONG_HOLD:   long_reg  <= cfg_data[6:0];
                    default:         max_v_reg <= max_v_reg;
                endcase
            end
            if (cmd.load) begin
                chan_reg <= 1'b0;
                if (key_presses[KEY_TRACK]) begin
                    track_reg <= track_reg ? 1'b0 : !(on_reg[0] || on_reg[1]);
                end
            end
            if (cmd.finish) begin
                chan_reg <= 1'b1;
                if (chan_reg && track_reg) begin
                    volt_reg[1]  <= volt_reg[0];
                    curr_reg[1]  <= curr_reg[0];
                    on_reg[1]    <= on_reg[0];
                    cmdon_reg[1] <= on_reg[0];
                end else begin
                    volt_reg[chan_reg] <= nv_reg;
                    curr_reg[chan_reg] <= ni_reg;
                    on_reg[chan_reg]   <= on_reg[chan_reg] ^ keys_reg[3'({chan_reg, 1'b0}) + 3'd1];
                    cmdon_reg[chan_reg] <= on_reg[chan_reg] ^
                                           keys_reg[3'({chan_reg, 1'b0}) + 3'd1];
                    if (keys_reg[3'({chan_reg, 1'b0}) + 3'd2]) begin
                        if (view_reg[chan_reg] == VIEW_PRESET) begin
                            view_reg[chan_reg] <= VIEW_READBACK;
                            if (dv_reg != 0 || di_reg != 0) hold_reg[chan_reg] <= long_reg;
                        end else begin
                            view_reg[chan_reg] <= VIEW_PRESET;
                            hold_reg[chan_reg] <= long_reg;
                        end
                    end else if (dv_reg != 0 || di_reg != 0) begin
                        if (view_reg[chan_reg] != VIEW_PRESET) begin
                            view_reg[chan_reg] <= VIEW_SETPOINT;
                            hold_reg[chan_reg] <= short_reg;
                        end else begin
                            hold_reg[chan_reg] <= long_reg;
                        end
                    end
                end
            end
            if (cmd.emit) begin
                for (int c = 0; c < 2; c++) begin
                    if (link_reg[c]) begin
                        if (on_reg[c] == last_reg[c]) on_reg[c] <= rep_reg[c];
                        else last_reg[c] <= on_reg[c];
                    end else begin
                        on_reg[c]   <= 1'b0;
                        last_reg[c] <= 1'b0;
                    end
                    if (hold_reg[c] != 7'd0) hold_reg[c] <= hold_reg[c] - 7'd1;
                    else view_reg[c] <= VIEW_READBACK;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_d_reg[0] <= volt_delta_a;
            in_d_reg[1] <= curr_delta_a;
            in_d_reg[2] <= volt_delta_b;
            in_d_reg[3] <= curr_delta_b;
            keys_reg    <= key_presses;
            link_reg    <= {link_ok_b, link_ok_a};
            rep_reg     <= {reported_on_b, reported_on_a};
        end
        if (cmd.adjust) begin
            dv_reg <= dv_c;
            di_reg <= di_c;
            nv_reg <= adj_v;
            ni_reg <= adj_i;
        end else if (div_done) begin
            if (div_cur_reg) ni_reg <= quot[SB-1:0];
            else nv_reg <= quot[SB-1:0];
        end
        if (cmd.div_start) div_cur_reg <= (dv_reg > 0);
    end

    assign volt_cmd_a  = 16'(volt_reg[0]);
    assign curr_cmd_a  = 16'(curr_reg[0]);
    assign volt_cmd_b  = 16'(volt_reg[1]);
    assign curr_cmd_b  = 16'(curr_reg[1]);
    assign on_cmd_a    = cmdon_reg[0];
    assign on_cmd_b    = cmdon_reg[1];
    assign tracking_on = track_reg;
    assign view_a      = view_reg[0];
    assign view_b      = view_reg[1];
endmodule

// ===== rtl/psu_panel_setpoint_controller_top.sv =====
// Top level of the two-channel panel setpoint controller.
//  channel  | handshake            | payload
//  s_       | s_valid / s_ready    | encoder deltas, keys, link status
//  m_       | m_valid / m_ready    | setpoints, enables, tracking, views
//  cfg_     | cfg_valid/cfg_ready  | cfg_index, cfg_data
// An item is loaded, then channel a and channel b in turn pass through adjust,
// limit, a restoring divide when the power limit is exceeded, and finish;
// the result is then offered on the m_ channel.
// Synchronous active-low reset restores config and panel state only.
// A result waits in the output registers until taken; no new item enters.
module psu_panel_setpoint_controller_top import psc_pkg::*; #(
    parameter int SETPOINT_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic signed [7:0] s_volt_delta_a,
    input  logic signed [7:0] s_curr_delta_a,
    input  logic signed [7:0] s_volt_delta_b,
    input  logic signed [7:0] s_curr_delta_b,
    input  logic [4:0]        s_key_presses,
    input  logic              s_link_ok_a,
    input  logic              s_reported_on_a,
    input  logic              s_link_ok_b,
    input  logic              s_reported_on_b,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_volt_cmd_a,
    output logic [15:0]       m_curr_cmd_a,
    output logic              m_on_cmd_a,
    output logic [15:0]       m_volt_cmd_b,
    output logic [15:0]       m_curr_cmd_b,
    output logic              m_on_cmd_b,
    output logic              m_tracking_on,
    output logic [1:0]        m_view_a,
    output logic [1:0]        m_view_b
);
    psc_cmd_t    cmd;
    psc_status_t status;

    assign cfg_ready = 1'b1;

    psc_controller u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .status    (status),
        .cmd       (cmd)
    );

    psc_datapath #(.SETPOINT_BITS(SETPOINT_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .volt_delta_a  (s_volt_delta_a),
        .curr_delta_a  (s_curr_delta_a),
        .volt_delta_b  (s_volt_delta_b),
        .curr_delta_b  (s_curr_delta_b),
        .key_presses   (s_key_presses),
        .link_ok_a     (s_link_ok_a),
        .reported_on_a (s_reported_on_a),
        .link_ok_b     (s_link_ok_b),
        .reported_on_b (s_reported_on_b),
        .volt_cmd_a    (m_volt_cmd_a),
        .curr_cmd_a    (m_curr_cmd_a),
        .on_cmd_a      (m_on_cmd_a),
        .volt_cmd_b    (m_volt_cmd_b),
        .curr_cmd_b    (m_curr_cmd_b),
        .on_cmd_b      (m_on_cmd_b),
        .tracking_on   (m_tracking_on),
        .view_a        (m_view_a),
        .view_b        (m_view_b)
    );
endmodule

// ===== verif/psc_checker.sv =====
// Checker for the panel setpoint controller: predicts each result and compares it.
`timescale 1ns / 100ps
module psc_checker import psc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic signed [7:0] s_volt_delta_a,
    input  logic signed [7:0] s_curr_delta_a,
    input  logic signed [7:0] s_volt_delta_b,
    input  logic signed [7:0] s_curr_delta_b,
    input  logic [4:0]        s_key_presses,
    input  logic              s_link_ok_a,
    input  logic              s_reported_on_a,
    input  logic              s_link_ok_b,
    input  logic              s_reported_on_b,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [15:0]       m_volt_cmd_a,
    input  logic [15:0]       m_curr_cmd_a,
    input  logic              m_on_cmd_a,
    input  logic [15:0]       m_volt_cmd_b,
    input  logic [15:0]       m_curr_cmd_b,
    input  logic              m_on_cmd_b,
    input  logic              m_tracking_on,
    input  logic [1:0]        m_view_a,
    input  logic [1:0]        m_view_b,
    output int                fail_count,
    output int                pending,
    output int                panel_count
);

    typedef struct packed {
        logic [15:0] volt_a;
        logic [15:0] curr_a;
        logic        on_a;
        logic [15:0] volt_b;
        logic [15:0] curr_b;
        logic        on_b;
        logic        trk;
        logic [1:0]  view_a;
        logic [1:0]  view_b;
    } panel_t;

    panel_t      panel_q[$];
    logic [15:0] lim_volt, lim_curr;
    logic [31:0] lim_power;
    logic [6:0]  hold_short, hold_long;
    logic [15:0] vset[2], iset[2];
    logic        en[2], en_last[2];
    logic [1:0]  vw[2];
    logic [6:0]  hold[2];
    logic        trk;

    function automatic int boost(input logic signed [7:0] d);
        int x;
        x = d;
        if (x > 1 || x < -1) x = x * 10;
        if (x > 30 || x < -30) x = x * 5;
        return x;
    endfunction

    function automatic logic [15:0] clamp(input logic [15:0] cur, input int d,
                                          input logic [15:0] lim);
        longint t;
        t = longint'(cur) + d;
        if (t < 0) t = 0;
        if (t > longint'(lim)) t = lim;
        return t[15:0];
    endfunction

    task automatic advance_panel(input logic signed [7:0] dlt[4], input logic [4:0] keys,
                                 input logic lnk[2], input logic rep[2]);
        panel_t p;
        int dv, di;
        logic [31:0] nv, ni;
        logic [63:0] prod;
        logic cmd[2];
        if (keys[KEY_TRACK]) trk = trk ? 1'b0 : !(en[0] || en[1]);
        for (int c = 0; c < 2; c++) begin
            dv = boost(dlt[c*2]);
            di = boost(dlt[c*2+1]);
            nv = clamp(vset[c], dv, lim_volt);
            ni = clamp(iset[c], di, lim_curr);
            if (c == 1 && trk) begin
                vset[1] = vset[0];
                iset[1] = iset[0];
                en[1] = en[0];
            end else begin
                if (dv != 0 || di != 0) begin
                    if (vw[c] != VIEW_PRESET) begin
                        hold[c] = hold_short;
                        vw[c] = VIEW_SETPOINT;
                    end else begin
                        hold[c] = hold_long;
                    end
                end
                prod = 64'(nv) * 64'(ni);
                if (prod > 64'(lim_power)) begin
                    if (dv > 0) ni = nv != 0 ? lim_power / nv : 0;
                    else nv = ni != 0 ? lim_power / ni : 0;
                end
                if (keys[c ? 3 : 1]) en[c] = !en[c];
                vset[c] = nv[15:0];
                iset[c] = ni[15:0];
                if (keys[c ? 4 : 2]) begin
                    if (vw[c] == VIEW_PRESET) begin
                        vw[c] = VIEW_READBACK;
                    end else begin
                        vw[c] = VIEW_PRESET;
                        hold[c] = hold_long;
                    end
                end
            end
            cmd[c] = en[c];
        end
        p = '{vset[0], iset[0], cmd[0], vset[1], iset[1], cmd[1], trk, vw[0], vw[1]};
        panel_q.push_back(p);
        for (int c = 0; c < 2; c++) begin
            if (lnk[c]) begin
                if (en[c] == en_last[c]) en[c] = rep[c];
                else en_last[c] = en[c];
            end else begin
                en[c] = 1'b0;
                en_last[c] = 1'b0;
            end
            if (hold[c] > 0) hold[c] = hold[c] - 1;
            else vw[c] = VIEW_READBACK;
        end
    endtask

    always @(posedge aclk) begin
        panel_t got, exp_p;
        logic signed [7:0] dlt[4];
        logic lnk[2], rep[2];
        if (!aresetn) begin
            lim_volt = 16'hffff; lim_curr = 16'hffff; lim_power = 32'hffffffff;
            hold_short = 7'd20; hold_long = 7'd100; trk = 1'b0;
            for (int c = 0; c < 2; c++) begin
                vset[c] = 0; iset[c] = 0; en[c] = 0; en_last[c] = 0;
                vw[c] = VIEW_READBACK; hold[c] = 0;
            end
            panel_q.delete();
            fail_count <= 0;
            panel_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MAX_VOLTAGE: lim_volt = cfg_data[15:0];
                    REG_MAX_CURRENT: lim_curr = cfg_data[15:0];
                    REG_MAX_POWER:   lim_power = cfg_data;
                    REG_SHORT_HOLD:  hold_short = cfg_data[6:0];
                    REG_LONG_HOLD:   hold_long = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                dlt = '{s_volt_delta_a, s_curr_delta_a, s_volt_delta_b, s_curr_delta_b};
                lnk = '{s_link_ok_a, s_link_ok_b};
                rep = '{s_reported_on_a, s_reported_on_b};
                advance_panel(dlt, s_key_presses, lnk, rep);
            end
            if (m_valid && m_ready) begin
                got = '{m_volt_cmd_a, m_curr_cmd_a, m_on_cmd_a, m_volt_cmd_b, m_curr_cmd_b,
                        m_on_cmd_b, m_tracking_on, m_view_a, m_view_b};
                panel_count <= panel_count + 1;
                if (panel_q.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_p = panel_q.pop_front();
                    if (got !== exp_p) begin
                        $display("%0t: mismatch expected %p", $time, exp_p);
                        $display("%0t:          actual   %p", $time, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= panel_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Stimulus and verdict for the panel setpoint controller.
`timescale 1ns / 100ps
module testbench;
    import psc_pkg::*;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0, cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [31:0]       cfg_data = '0;
    logic              s_valid = 1'b0, s_ready;
    logic signed [7:0] s_volt_delta_a = '0, s_curr_delta_a = '0;
    logic signed [7:0] s_volt_delta_b = '0, s_curr_delta_b = '0;
    logic [4:0]        s_key_presses = '0;
    logic              s_link_ok_a = 1'b0, s_reported_on_a = 1'b0;
    logic              s_link_ok_b = 1'b0, s_reported_on_b = 1'b0;
    logic              m_valid, m_ready = 1'b0;
    logic [15:0]       m_volt_cmd_a, m_curr_cmd_a, m_volt_cmd_b, m_curr_cmd_b;
    logic              m_on_cmd_a, m_on_cmd_b, m_tracking_on;
    logic [1:0]        m_view_a, m_view_b;
    int                fail_count, pending, panel_count;
    int                idle_pct = 18;
    bit                hold_off = 1'b0;
    int                quiet = 0;
    int                ticks_sent = 0;

    always #5 aclk = ~aclk;

    psu_panel_setpoint_controller_top DUT (.*);
    psc_checker u_checker (.*);

    always @(posedge aclk) begin
        if (m_valid && m_ready || s_valid && s_ready || cfg_valid && cfg_ready) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > 20000) begin
            $display("Timeout: no item accepted for %0d cycles", quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= $urandom_range(99) >= idle_pct;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_tick(input logic signed [7:0] va, ia, vb, ib, input logic [4:0] k,
                             input logic [3:0] st);
        while ($urandom_range(99) < idle_pct) @(posedge aclk);
        s_valid <= 1'b1;
        s_volt_delta_a <= va; s_curr_delta_a <= ia;
        s_volt_delta_b <= vb; s_curr_delta_b <= ib;
        s_key_presses <= k;
        {s_link_ok_a, s_reported_on_a, s_link_ok_b, s_reported_on_b} <= st;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        ticks_sent++;
        @(posedge aclk);
    endtask

    task automatic drain;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic logic signed [7:0] knob;
        case ($urandom_range(3))
            0: return 0;
            1: return 8'($signed($urandom_range(2)) - 1);
            2: return 8'($signed($urandom_range(12)) - 6);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_ticks(input int n);
        logic [4:0] k;
        for (int i = 0; i < n; i++) begin
            k = ($urandom_range(3) == 0) ? 5'($urandom) : 5'd0;
            send_tick(knob(), knob(), knob(), knob(), k,
                      ($urandom_range(7) == 0) ? 4'($urandom) : {1'b1, 1'($urandom),
                      1'b1, 1'($urandom)});
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: extremes, keys, power limit, tracking
        send_tick(127, 127, -128, -128, 5'b00000, 4'b1010);
        send_tick(1, -1, 2, -2, 5'b00101, 4'b1111);
        send_tick(127, 127, 127, 127, 5'b11010, 4'b1111);
        send_tick(-128, -128, 0, 0, 5'b00001, 4'b0000);
        send_tick(0, 0, 0, 0, 5'b00001, 4'b1010);
        send_tick(7, 3, 5, 5, 5'b11111, 4'b1111);
        send_tick(0, 0, 0, 0, 5'b00001, 4'b0101);
        send_tick(-3, 31, 0, 0, 5'b10100, 4'b1000);
        drain();
        write_reg(REG_MAX_POWER, 32'd0);
        write_reg(REG_SHORT_HOLD, 32'd0);
        write_reg(REG_LONG_HOLD, 32'd0);
        send_tick(127, 127, 127, 127, 5'b10100, 4'b1111);
        send_tick(-128, 5, 5, -128, 5'b00000, 4'b1111);
        send_tick(0, 0, 0, 0, 5'b00000, 4'b1111);
        drain();
        write_reg(REG_MAX_VOLTAGE, 32'd0);
        write_reg(REG_MAX_CURRENT, 32'd0);
        write_reg(REG_SHORT_HOLD, 32'd127);
        write_reg(REG_LONG_HOLD, 32'd127);
        send_tick(127, 127, 127, 127, 5'b00000, 4'b1111);
        drain();
        write_reg(REG_MAX_VOLTAGE, 32'd3000);
        write_reg(REG_MAX_CURRENT, 32'd2000);
        write_reg(REG_MAX_POWER, 32'd1500000);
        write_reg(REG_SHORT_HOLD, 32'd5);
        write_reg(REG_LONG_HOLD, 32'd12);
        random_ticks(500);
        // hold off the receiver so the block backs up
        hold_off = 1'b1;
        fork
            random_ticks(20);
            begin
                repeat (600) @(posedge aclk);
                hold_off = 1'b0;
            end
        join
        idle_pct = 0;
        random_ticks(300);
        idle_pct = 18;
        drain();
        write_reg(REG_MAX_VOLTAGE, 32'hffff);
        write_reg(REG_MAX_CURRENT, 32'hffff);
        write_reg(REG_MAX_POWER, 32'hffffffff);
        write_reg(REG_SHORT_HOLD, 32'd20);
        write_reg(REG_LONG_HOLD, 32'd100);
        random_ticks(500);
        drain();
        write_reg(REG_MAX_VOLTAGE, 32'd400);
        write_reg(REG_MAX_CURRENT, 32'd700);
        write_reg(REG_MAX_POWER, 32'd60000);
        write_reg(REG_SHORT_HOLD, 32'd1);
        write_reg(REG_LONG_HOLD, 32'd3);
        random_ticks(480);
        drain();
        $display("Covered %0d ticks, %0d results checked, under six register settings", ticks_sent,
                 panel_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
